// ===== hdl/multicast_cohort_handshake_macros.svh =====
// Assertion macros shared by the cohort handshake modules.
`ifndef MULTICAST_COHORT_HANDSHAKE_MACROS_SVH
`define MULTICAST_COHORT_HANDSHAKE_MACROS_SVH
`ifndef SYNTHESIS
`define MCH_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define MCH_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define MCH_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define MCH_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mch_pkg.sv =====
// Types, constants and checksum helper for the cohort handshake block.
package mch_pkg;

   localparam int MAX_PEERS_DEF = 16;
   localparam int QDEPTH        = 2;

   // Input operation codes. Code three is undefined and ignored.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_HDR   = 2'd2;
   localparam logic [1:0] OP_UNDEF = 2'd3;

   // Result event codes.
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SYN   = 2'd1;
   localparam logic [1:0] EV_START = 2'd2;
   localparam logic [1:0] EV_FAIL  = 2'd3;

   // Header flag bits.
   localparam logic [15:0] FLAG_SYN   = 16'h0001;
   localparam logic [15:0] FLAG_ACK   = 16'h0002;
   localparam logic [15:0] FLAG_START = 16'h0004;
   localparam logic [15:0] TX_WINDOW  = 16'h0001;

   // Configuration register indexes.
   localparam logic [1:0] CSR_EXPECTED = 2'd0;
   localparam logic [1:0] CSR_RTO      = 2'd1;
   localparam logic [1:0] CSR_RETRIES  = 2'd2;
   localparam logic [1:0] CSR_SPORT    = 2'd3;

   typedef enum logic [1:0] {
      CLS_START,
      CLS_TICK,
      CLS_HDR,
      CLS_IGNORE
   } cls_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef struct packed {
      logic [4:0]  expected_peers;
      logic [15:0] rto_ticks;
      logic [7:0]  max_retries;
      logic [15:0] tx_port;
   } cfg_type;

   typedef struct packed {
      cls_type     cls;
      logic [31:0] time_ms;
      logic [47:0] key;
      logic [31:0] tsecr;
      logic        hdr_good;
      logic [15:0] csum_syn;
      logic [15:0] csum_start;
   } entry_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [15:0] pkt_flags;
      logic [31:0] pkt_tsval;
      logic [15:0] pkt_src_port;
      logic [15:0] pkt_checksum;
      logic [4:0]  peers_found;
      logic        done_res;
   } rsp_type;

   // End-around carry fold of a sum of up to sixteen 16-bit words, then
   // complement. Two folds always settle such a sum into 16 bits.
   function automatic logic [15:0] csum_fold(input logic [19:0] s);
      logic [16:0] a;
      logic [15:0] b;
      a = {1'b0, s[15:0]} + {13'b0, s[19:16]};
      b = a[15:0] + {15'b0, a[16]};
      return ~b;
   endfunction

endpackage

// ===== hdl/mch_front.sv =====
// Front part: classifies an incoming word and works out its checksums.
module mch_front (
   input  logic [1:0]         op,
   input  logic [239:0]       data,
   input  logic [15:0]        tx_port,
   output mch_pkg::entry_type entry
);

   logic [31:0] time_ms, peer_ip, seq, tsval, tsecr;
   logic [15:0] peer_port, sport, flags, wnd, csum;
   logic [19:0] rx_sum;
   logic [19:0] tx_base;
   logic        flags_ok;

   assign time_ms   = data[31:0];
   assign peer_ip   = data[63:32];
   assign peer_port = data[79:64];
   assign seq       = data[111:80];
   assign sport     = data[127:112];
   assign flags     = data[143:128];
   assign wnd       = data[159:144];
   assign csum      = data[175:160];
   assign tsval     = data[207:176];
   assign tsecr     = data[239:208];

   assign rx_sum = 20'(seq[31:16]) + 20'(seq[15:0]) + 20'(sport) + 20'(flags)
                 + 20'(wnd) + 20'(tsval[31:16]) + 20'(tsval[15:0])
                 + 20'(tsecr[31:16]) + 20'(tsecr[15:0]);

   // Sent header: sequence and echo are zero, window is one.
   assign tx_base = 20'(tx_port) + 20'(mch_pkg::TX_WINDOW)
                  + 20'(time_ms[31:16]) + 20'(time_ms[15:0]);

   assign flags_ok = (flags & (mch_pkg::FLAG_SYN | mch_pkg::FLAG_ACK))
                     == (mch_pkg::FLAG_SYN | mch_pkg::FLAG_ACK);

   always_comb begin
      unique case (op)
         mch_pkg::OP_START: entry.cls = mch_pkg::CLS_START;
         mch_pkg::OP_TICK:  entry.cls = mch_pkg::CLS_TICK;
         mch_pkg::OP_HDR:   entry.cls = mch_pkg::CLS_HDR;
         mch_pkg::OP_UNDEF: entry.cls = mch_pkg::CLS_IGNORE;
      endcase
      entry.time_ms    = time_ms;
      entry.key        = {peer_ip, peer_port};
      entry.tsecr      = tsecr;
      entry.hdr_good   = (mch_pkg::csum_fold(rx_sum) == csum) && flags_ok;
      entry.csum_syn   = mch_pkg::csum_fold(tx_base + 20'(mch_pkg::FLAG_SYN));
      entry.csum_start = mch_pkg::csum_fold(tx_base + 20'(mch_pkg::FLAG_START));
   end

endmodule

// ===== hdl/mch_queue.sv =====
// Short queue between the front and back parts.
`include "multicast_cohort_handshake_macros.svh"
module mch_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mch_pkg::entry_type push_entry,
   output logic               not_full,
   input  logic               pop,
   output logic               head_valid,
   output mch_pkg::entry_type head_entry
);

   localparam int PW = $clog2(mch_pkg::QDEPTH);
   localparam int CW = $clog2(mch_pkg::QDEPTH + 1);

   mch_pkg::entry_type slot_ff [mch_pkg::QDEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign not_full   = count_ff != CW'(mch_pkg::QDEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(mch_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(mch_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MCH_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(mch_pkg::QDEPTH))
   `MCH_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, count_ff != '0)
   `MCH_ASSERT_IMPLIES(a_no_push_full, clock, reset, push, count_ff != CW'(mch_pkg::QDEPTH))

endmodule

// ===== hdl/mch_back.sv =====
// Back part: handshake state, peer table and the result register.
`include "multicast_cohort_handshake_macros.svh"
module mch_back #(
   parameter int MAX_PEERS = mch_pkg::MAX_PEERS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mch_pkg::cfg_type   cfg,
   input  logic               head_valid,
   input  mch_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mch_pkg::rsp_type   rsp
);

   localparam int CW = $clog2(MAX_PEERS + 1);
   localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int EW = (CW > 5) ? CW : 5;

   mch_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        stamp_ff, stamp_in;
   logic [7:0]         attempt_ff, attempt_in;
   logic [15:0]        timer_ff, timer_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [47:0]        table_ff [MAX_PEERS];
   logic               tbl_we;
   logic               rsp_valid_ff, rsp_valid_in;
   mch_pkg::rsp_type   rsp_ff, rsp_in;
   logic [MAX_PEERS-1:0] hit;
   logic               known;
   logic               accepted;

   assign pop       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Each table entry is compared in parallel; only filled entries count.
   always_comb begin
      for (int i = 0; i < MAX_PEERS; i++) begin
         hit[i] = (CW'(i) < count_ff) && (table_ff[i] == head_entry.key);
      end
      known = |hit;
   end

   assign accepted = (head_entry.hdr_good && head_entry.tsecr == stamp_ff);

   always_comb begin
      phase_in     = phase_ff;
      stamp_in     = stamp_ff;
      attempt_in   = attempt_ff;
      timer_in     = timer_ff;
      count_in     = count_ff;
      tbl_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (pop) begin
         rsp_valid_in        = 1'b1;
         rsp_in.event_res    = mch_pkg::EV_NONE;
         rsp_in.pkt_flags    = '0;
         rsp_in.pkt_tsval    = '0;
         rsp_in.pkt_src_port = '0;
         rsp_in.pkt_checksum = '0;
         unique case (head_entry.cls)
            mch_pkg::CLS_START: begin
               count_in            = '0;
               attempt_in          = '0;
               phase_in            = mch_pkg::PH_WAIT;
               stamp_in            = head_entry.time_ms;
               timer_in            = cfg.rto_ticks;
               rsp_in.event_res    = mch_pkg::EV_SYN;
               rsp_in.pkt_flags    = mch_pkg::FLAG_SYN;
               rsp_in.pkt_tsval    = head_entry.time_ms;
               rsp_in.pkt_src_port = cfg.tx_port;
               rsp_in.pkt_checksum = head_entry.csum_syn;
            end
            mch_pkg::CLS_TICK: begin
               if (phase_ff == mch_pkg::PH_WAIT) begin
                  if (timer_ff > 16'd1) begin
                     timer_in = timer_ff - 16'd1;
                  end else if (attempt_ff < cfg.max_retries) begin
                     attempt_in          = attempt_ff + 8'd1;
                     stamp_in            = head_entry.time_ms;
                     timer_in            = cfg.rto_ticks;
                     rsp_in.event_res    = mch_pkg::EV_SYN;
                     rsp_in.pkt_flags    = mch_pkg::FLAG_SYN;
                     rsp_in.pkt_tsval    = head_entry.time_ms;
                     rsp_in.pkt_src_port = cfg.tx_port;
                     rsp_in.pkt_checksum = head_entry.csum_syn;
                  end else begin
                     timer_in         = '0;
                     phase_in         = mch_pkg::PH_FAIL;
                     rsp_in.event_res = mch_pkg::EV_FAIL;
                  end
               end
            end
            mch_pkg::CLS_HDR: begin
               if (phase_ff == mch_pkg::PH_WAIT && accepted) begin
                  if (!known && count_ff < CW'(MAX_PEERS)) begin
                     tbl_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
                  if (EW'(count_in) >= EW'(cfg.expected_peers)) begin
                     phase_in            = mch_pkg::PH_DONE;
                     rsp_in.event_res    = mch_pkg::EV_START;
                     rsp_in.pkt_flags    = mch_pkg::FLAG_START;
                     rsp_in.pkt_tsval    = head_entry.time_ms;
                     rsp_in.pkt_src_port = cfg.tx_port;
                     rsp_in.pkt_checksum = head_entry.csum_start;
                  end
               end
            end
            default: begin
            end
         endcase
         rsp_in.peers_found = 5'(count_in);
         rsp_in.done_res    = (phase_in == mch_pkg::PH_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mch_pkg::PH_IDLE;
         stamp_ff     <= '0;
         attempt_ff   <= '0;
         timer_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         stamp_ff     <= stamp_in;
         attempt_ff   <= attempt_in;
         timer_ff     <= timer_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (tbl_we) begin
         table_ff[count_ff[IW-1:0]] <= head_entry.key;
      end
   end

   `MCH_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(MAX_PEERS))
   `MCH_ASSERT_IMPLIES(a_pop_has_head, clock, reset, pop, head_valid)
   `MCH_ASSERT_IMPLIES(a_quiet_no_pkt, clock, reset, rsp_valid_ff && (rsp_ff.event_res == mch_pkg::EV_NONE || rsp_ff.event_res == mch_pkg::EV_FAIL), rsp_ff.pkt_flags == '0 && rsp_ff.pkt_checksum == '0)

endmodule

// ===== hdl/multicast_cohort_handshake.sv =====
// A word accepted on req_ is written into the queue; once popped, which waits
// while rsp_ is stalled, it is registered into the result register on rsp_.
// Throughput: one word per cycle, ticks and headers back to back, while rsp_
// is not stalled; set by the back part's single state update, one queue entry a cycle.
// Reset (reset, synchronous, active high) clears the phase, timers, counters,
// queue and valid flags and loads the register defaults; the peer table is not
// cleared, as only entries below the peer count are ever compared.
module multicast_cohort_handshake #(
   parameter int MAX_PEERS = mch_pkg::MAX_PEERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // From bit 0: time_ms, peer_ip, peer_port, hdr_seq, hdr_src_port,
   // hdr_flags, hdr_window, hdr_checksum, hdr_tsval, hdr_tsecr.
   input  logic [239:0] req_tdata,
   // op.
   input  logic [1:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // From bit 0: pkt_flags, pkt_tsval, pkt_src_port, pkt_checksum,
   // peers_found, done_res, two zero bits.
   output logic [87:0]  rsp_tdata,
   // event_res.
   output logic [1:0]   rsp_tuser,
   // Register write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   mch_pkg::cfg_type   cfg_ff, cfg_in;
   mch_pkg::entry_type front_entry, head_entry;
   mch_pkg::rsp_type   rsp;
   logic               q_not_full, head_valid, pop, push;

   // Register writes are always taken at once. They are meant to be issued only
   // while no word is in flight, as words already queued carry checksums built
   // from the old source port.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mch_pkg::CSR_EXPECTED: cfg_in.expected_peers = csr_wdata[4:0];
            mch_pkg::CSR_RTO:      cfg_in.rto_ticks      = csr_wdata;
            mch_pkg::CSR_RETRIES:  cfg_in.max_retries    = csr_wdata[7:0];
            mch_pkg::CSR_SPORT:    cfg_in.tx_port        = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_peers <= 5'd1;
         cfg_ff.rto_ticks      <= 16'd250;
         cfg_ff.max_retries    <= 8'd20;
         cfg_ff.tx_port        <= 16'd45000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front part classifies each word and precomputes every checksum it
   // may need, so the back part only has state to update.
   mch_front u_front (
      .op      (req_tuser),
      .data    (req_tdata),
      .tx_port (cfg_ff.tx_port),
      .entry   (front_entry)
   );

   assign req_tready = q_not_full;
   assign push       = req_tvalid && q_not_full;

   mch_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .not_full   (q_not_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mch_back #(
      .MAX_PEERS (MAX_PEERS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.event_res;
   assign rsp_tdata = {2'b00, rsp.done_res, rsp.peers_found, rsp.pkt_checksum,
                       rsp.pkt_src_port, rsp.pkt_tsval, rsp.pkt_flags};

endmodule
